### rtl/core/pgic_pkg.sv
// ----------------------------------------------------------------------------
// pgic_pkg
// Shared types and constants for the pixel gray / invert / gain / contrast core
// ----------------------------------------------------------------------------
package pgic_pkg;

    localparam int NumChan   = 4;
    localparam int ChanWidth = 8;
    localparam int GainWidth = 16;
    localparam int CntWidth  = 3;

    // q16 luma weights, they sum to 65536
    localparam logic [15:0] LumaW0 = 16'd19595;
    localparam logic [15:0] LumaW1 = 16'd38470;
    localparam logic [15:0] LumaW2 = 16'd7471;

    localparam logic [ChanWidth-1:0] FullScale = 8'd255;
    localparam logic [ChanWidth-1:0] MidLevel  = 8'd128;

    // register reset values
    localparam logic [CntWidth-1:0]  ChanCountRst      = 3'd3;
    localparam logic [GainWidth-1:0] BrightnessGainRst = 16'd307;
    localparam logic [GainWidth-1:0] ContrastGainRst   = 16'd333;

    typedef logic [ChanWidth-1:0] chan_t;
    typedef logic [NumChan-1:0]   chan_mask_t;

    typedef enum logic [1:0] {
        CFG_CHANNEL_COUNT   = 2'd0,
        CFG_BRIGHTNESS_GAIN = 2'd1,
        CFG_CONTRAST_GAIN   = 2'd2
    } cfg_index_t;

endpackage

### rtl/core/pixel_gray_invert_gain_contrast.sv
// ----------------------------------------------------------------------------
// pixel_gray_invert_gain_contrast
// Four-channel pixel pipe: luma gray, invert, brightness gain, contrast gain
// ----------------------------------------------------------------------------
// pipeline: four register stages, s1 to s4, the input word passes
//   through each in turn to the output
// throughput: one word per cycle while out_ready is high, each stage holds one word and holds
//   only while the stage ahead of it is full and stalled
// reset: rst_n asynchronous active low, empties the pipe and loads
//   channel_count 3, brightness_gain 307, contrast_gain 333
module pixel_gray_invert_gain_contrast (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [pgic_pkg::GainWidth-1:0]  cfg_data,
    // input word
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pgic_pkg::ChanWidth-1:0]  in_chan0,
    input  logic [pgic_pkg::ChanWidth-1:0]  in_chan1,
    input  logic [pgic_pkg::ChanWidth-1:0]  in_chan2,
    input  logic [pgic_pkg::ChanWidth-1:0]  in_chan3,
    // output word
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pgic_pkg::ChanWidth-1:0]  out_chan0,
    output logic [pgic_pkg::ChanWidth-1:0]  out_chan1,
    output logic [pgic_pkg::ChanWidth-1:0]  out_chan2,
    output logic [pgic_pkg::ChanWidth-1:0]  out_chan3
);
    import pgic_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CntWidth-1:0]         chan_count_reg;
    logic signed [GainWidth-1:0] bright_gain_reg;
    logic signed [GainWidth-1:0] contrast_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg    <= ChanCountRst;
            bright_gain_reg   <= BrightnessGainRst;
            contrast_gain_reg <= ContrastGainRst;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CHANNEL_COUNT:   chan_count_reg    <= cfg_data[CntWidth-1:0];
                CFG_BRIGHTNESS_GAIN: bright_gain_reg   <= cfg_data;
                CFG_CONTRAST_GAIN:   contrast_gain_reg <= cfg_data;
                default:             ; // unknown index, write dropped
            endcase
        end
    end

    // channels in use, counts above four saturate
    logic [CntWidth-1:0] used_chan;
    logic                gray_en;
    chan_mask_t          chan_en;

    always_comb
    begin
        used_chan = (chan_count_reg > CntWidth'(NumChan)) ? CntWidth'(NumChan)
                                                          : chan_count_reg;
        gray_en   = (used_chan >= CntWidth'(3));
        for (int i = 0; i < NumChan; i++)
        begin
            chan_en[i] = (CntWidth'(i) < used_chan);
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake: a stage takes a word when it is empty or when
    // the stage ahead of it is taking its word
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: luma (three weight products and two adds), gray select
    // ------------------------------------------------------------------
    logic [23:0] luma_sum;
    chan_t       luma;
    chan_t       s1_chan_next [NumChan];
    chan_t       s1_chan_reg  [NumChan];
    chan_mask_t  s1_en_reg;

    always_comb
    begin
        luma_sum = (24'(LumaW0) * 24'(in_chan0))
                 + (24'(LumaW1) * 24'(in_chan1))
                 + (24'(LumaW2) * 24'(in_chan2));
        luma     = luma_sum[23:16];
        s1_chan_next[0] = gray_en ? luma : in_chan0;
        s1_chan_next[1] = gray_en ? luma : in_chan1;
        s1_chan_next[2] = gray_en ? luma : in_chan2;
        s1_chan_next[3] = in_chan3; // alpha never goes gray
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_chan_reg <= s1_chan_next;
            s1_en_reg   <= chan_en;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: invert, then brightness product per lane
    // ------------------------------------------------------------------
    logic signed [24:0] s2_prod_next [NumChan];
    logic signed [24:0] s2_prod_reg  [NumChan];
    chan_mask_t         s2_en_reg;

    always_comb
    begin
        for (int i = 0; i < NumChan; i++)
        begin
            s2_prod_next[i] = $signed({1'b0, FullScale - s1_chan_reg[i]}) * bright_gain_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_prod_reg <= s2_prod_next;
            s2_en_reg   <= s1_en_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: floor and clamp brightness, then contrast product about mid
    // ------------------------------------------------------------------
    logic signed [16:0] s3_bright_q   [NumChan];
    chan_t              s3_bright     [NumChan];
    logic signed [8:0]  s3_centered   [NumChan];
    logic signed [24:0] s3_prod_next  [NumChan];
    logic signed [24:0] s3_prod_reg   [NumChan];
    chan_mask_t         s3_en_reg;

    always_comb
    begin
        for (int i = 0; i < NumChan; i++)
        begin
            // arithmetic shift by 8 is the floor of the q8.8 product
            s3_bright_q[i] = s2_prod_reg[i][24:8];
            if (s3_bright_q[i] < 17'sd0)
            begin
                s3_bright[i] = '0;
            end
            else if (s3_bright_q[i] > 17'sd255)
            begin
                s3_bright[i] = FullScale;
            end
            else
            begin
                s3_bright[i] = s3_bright_q[i][7:0];
            end
            s3_centered[i]  = $signed({1'b0, s3_bright[i]}) - $signed({1'b0, MidLevel});
            s3_prod_next[i] = s3_centered[i] * contrast_gain_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            s3_prod_reg <= s3_prod_next;
            s3_en_reg   <= s2_en_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: floor, re-center, clamp, zero unused lanes
    // ------------------------------------------------------------------
    logic signed [17:0] s4_level [NumChan];
    chan_t              s4_chan_next [NumChan];
    chan_t              s4_chan_reg  [NumChan];

    always_comb
    begin
        for (int i = 0; i < NumChan; i++)
        begin
            // floored product keeps its sign when widened
            s4_level[i] = 18'($signed(s3_prod_reg[i][24:8])) + $signed({10'd0, MidLevel});
            if (!s3_en_reg[i] || s4_level[i] < 18'sd0)
            begin
                s4_chan_next[i] = '0;
            end
            else if (s4_level[i] > 18'sd255)
            begin
                s4_chan_next[i] = FullScale;
            end
            else
            begin
                s4_chan_next[i] = s4_level[i][7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s4_ready)
        begin
            s4_chan_reg <= s4_chan_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_chan0 = s4_chan_reg[0];
    assign out_chan1 = s4_chan_reg[1];
    assign out_chan2 = s4_chan_reg[2];
    assign out_chan3 = s4_chan_reg[3];

endmodule

### rtl/core/pgic_checker.sv
// ----------------------------------------------------------------------------
// pgic_checker
// Port-level checks for the pixel gray / invert / gain / contrast core
// ----------------------------------------------------------------------------
module pgic_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_write,
    input logic [1:0]                      cfg_index,
    input logic [pgic_pkg::GainWidth-1:0]  cfg_data,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [pgic_pkg::ChanWidth-1:0]  in_chan0,
    input logic [pgic_pkg::ChanWidth-1:0]  in_chan1,
    input logic [pgic_pkg::ChanWidth-1:0]  in_chan2,
    input logic [pgic_pkg::ChanWidth-1:0]  in_chan3,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [pgic_pkg::ChanWidth-1:0]  out_chan0,
    input logic [pgic_pkg::ChanWidth-1:0]  out_chan1,
    input logic [pgic_pkg::ChanWidth-1:0]  out_chan2,
    input logic [pgic_pkg::ChanWidth-1:0]  out_chan3
);
    import pgic_pkg::*;

    // shadow of the channel count as written on the port
    logic [CntWidth-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= ChanCountRst;
        end
        else if (cfg_write && cfg_index == CFG_CHANNEL_COUNT)
        begin
            cnt_reg <= cfg_data[CntWidth-1:0];
        end
    end

    // pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output word valid during reset");

    // an empty output stage means the whole pipe can take a word
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_chan0)
            && $stable(out_chan1) && $stable(out_chan2) && $stable(out_chan3))
        else $error("stalled output word changed");

    // gray mode gives equal first three channels
    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cnt_reg >= 3'd3 |-> out_chan0 == out_chan1 && out_chan1 == out_chan2)
        else $error("gray channels differ");

    // with a channel count of one or less, channels 1 to 3 read zero
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cnt_reg <= 3'd1 |-> out_chan1 == '0 && out_chan2 == '0
            && out_chan3 == '0)
        else $error("unused channel not zero");

endmodule

bind pixel_gray_invert_gain_contrast pgic_checker u_pgic_checker (.*);
